### hw/rtl/efj_pkg.sv
// efj_pkg: shared constants, types and fixed-point helpers for the euler flux block
// used by every module under hw/rtl
package efj_pkg;

	localparam int DEF_SPACE_DIMS = 3;
	localparam int DEF_FRAC_BITS  = 16;
	localparam int DATA_W  = 32;
	localparam int GAMMA_W = 18;
	localparam int IDX_W   = 3;
	localparam int CFG_IDX_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_GAMMA_RATIO = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_JAC_ENABLE  = 8'd1;
	localparam logic [GAMMA_W-1:0]   GAMMA_RESET     = 18'd91750;

	localparam logic KIND_FLUX = 1'b0;
	localparam logic KIND_JAC  = 1'b1;

	localparam logic signed [63:0] MAX32 = 64'sd2147483647;
	localparam logic signed [63:0] MIN32 = -64'sd2147483648;

	// shared node quantities handed from the front end to the row sequencer
	typedef struct packed {
		logic signed [DATA_W-1:0] m0, m1, m2;
		logic signed [DATA_W-1:0] u0, u1, u2;
		logic signed [DATA_W-1:0] p, ep, h, alpha, beta;
		logic signed [DATA_W-1:0] gam, gm1, gm3;
		logic bad;
		logic pre_sat;
		logic jac;
	} node_t;

	// row tag carried with a row through the back end
	typedef struct packed {
		logic kind;
		logic [IDX_W-1:0] eq;
		logic [IDX_W-1:0] vr;
		logic last;
		logic bad;
	} row_tag_t;

	// saturate a wide signed value to 32 bits
	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
		logic signed [DATA_W-1:0] r;
		if (v > MAX32) r = MAX32[DATA_W-1:0];
		else if (v < MIN32) r = MIN32[DATA_W-1:0];
		else r = v[DATA_W-1:0];
		return r;
	endfunction

	function automatic logic ovf32(input logic signed [63:0] v);
		return (v > MAX32) || (v < MIN32);
	endfunction

endpackage

### hw/rtl/efj_recip.sv
// efj_recip: pipelined restoring divider for trunc(2^(2F) / rho), one quotient bit a stage
// depends on efj_pkg
module efj_recip import efj_pkg::*; #(
	parameter int FRAC_BITS = DEF_FRAC_BITS,
	parameter int TAG_W = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic [DATA_W-2:0] divisor,
	input  logic [TAG_W-1:0] in_tag,
	output logic out_valid,
	output logic [2*FRAC_BITS:0] quotient,
	output logic [TAG_W-1:0] out_tag
);
	localparam int QW = 2*FRAC_BITS + 1;
	localparam int RW = DATA_W;

	logic [RW-1:0] rem_s1 [QW+1];
	logic [QW-1:0] quo_s1 [QW+1];
	logic [DATA_W-2:0] dv_s1 [QW+1];
	logic [TAG_W-1:0] tag_s1 [QW+1];
	logic vld_s1 [QW+1];

	always_comb begin
		rem_s1[0] = '0;
		quo_s1[0] = '0;
		dv_s1[0]  = divisor;
		tag_s1[0] = in_tag;
		vld_s1[0] = in_valid;
	end

	// one restoring step per stage, dividend bits from the top (only bit 2F is one)
	for (genvar i = 0; i < QW; i++) begin : g_step
		logic [RW:0] shr;
		logic [RW:0] dif;
		always_comb begin
			shr = {rem_s1[i], (i == 0) ? 1'b1 : 1'b0};
			dif = shr - {2'b0, dv_s1[i]};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s1[i+1] <= 1'b0;
			end else if (en) begin
				vld_s1[i+1] <= vld_s1[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (!dif[RW]) begin
					rem_s1[i+1] <= dif[RW-1:0];
					quo_s1[i+1] <= {quo_s1[i][QW-2:0], 1'b1};
				end else begin
					rem_s1[i+1] <= shr[RW-1:0];
					quo_s1[i+1] <= {quo_s1[i][QW-2:0], 1'b0};
				end
				dv_s1[i+1]  <= dv_s1[i];
				tag_s1[i+1] <= tag_s1[i];
			end
		end
	end

	assign out_valid = vld_s1[QW];
	assign quotient  = quo_s1[QW];
	assign out_tag   = tag_s1[QW];
endmodule

### hw/rtl/efj_front.sv
// efj_front: node front end, reciprocal then staged velocity, pressure and enthalpy terms
// depends on efj_pkg and efj_recip
module efj_front import efj_pkg::*; #(
	parameter int SPACE_DIMS = DEF_SPACE_DIMS,
	parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic signed [DATA_W-1:0] density,
	input  logic signed [DATA_W-1:0] momentum_x,
	input  logic signed [DATA_W-1:0] momentum_y,
	input  logic signed [DATA_W-1:0] momentum_z,
	input  logic signed [DATA_W-1:0] total_energy,
	input  logic [GAMMA_W-1:0] gamma_ratio,
	input  logic jac_en,
	output logic out_valid,
	output node_t node
);
	localparam int TW = 5*DATA_W + GAMMA_W + 2;
	localparam int QW = 2*FRAC_BITS + 1;
	localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;

	logic [TW-1:0] tag_in, tag_out;
	logic rv;
	logic [QW-1:0] quo;
	logic rho_bad;

	assign rho_bad = (density <= 0);
	assign tag_in = {density, momentum_x, momentum_y,
		(SPACE_DIMS > 2) ? momentum_z : {DATA_W{1'b0}}, total_energy, gamma_ratio, jac_en, rho_bad};

	efj_recip #(.FRAC_BITS(FRAC_BITS), .TAG_W(TW)) u_recip (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(in_valid),
		.divisor(rho_bad ? {{(DATA_W-2){1'b0}}, 1'b1} : density[DATA_W-2:0]),
		.in_tag(tag_in), .out_valid(rv), .quotient(quo), .out_tag(tag_out));

	// unpack tag
	logic signed [DATA_W-1:0] rho_a, m0_a, m1_a, m2_a, e_a;
	logic [GAMMA_W-1:0] g_a;
	logic jac_a, bad_a;
	assign {rho_a, m0_a, m1_a, m2_a, e_a, g_a, jac_a, bad_a} = tag_out;

	// stage a: saturate reciprocal, constants from gamma
	logic va_s1;
	logic signed [DATA_W-1:0] rinv_s1, rho_s1, m0_s1, m1_s1, m2_s1, e_s1, gam_s1, gm1_s1, gm3_s1;
	logic jac_s1, bad_s1, sat_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) va_s1 <= 1'b0;
		else if (en) va_s1 <= rv;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			rinv_s1 <= sat32(64'(quo));
			sat_s1  <= ovf32(64'(quo));
			rho_s1 <= rho_a; m0_s1 <= m0_a; m1_s1 <= m1_a; m2_s1 <= m2_a; e_s1 <= e_a;
			gam_s1 <= DATA_W'(g_a);
			gm1_s1 <= DATA_W'($signed({1'b0, g_a}) - ONE);
			gm3_s1 <= DATA_W'($signed({1'b0, g_a}) - 3*ONE);
			jac_s1 <= jac_a; bad_s1 <= bad_a;
		end
	end

	// stage b: velocities
	logic vb_s2;
	logic signed [DATA_W-1:0] u0_s2, u1_s2, u2_s2, rinv_s2, rho_s2, m0_s2, m1_s2, m2_s2, e_s2;
	logic signed [DATA_W-1:0] gam_s2, gm1_s2, gm3_s2;
	logic jac_s2, bad_s2, sat_s2;
	logic signed [63:0] pu0, pu1, pu2;
	assign pu0 = (64'(rinv_s1) * 64'(m0_s1)) >>> FRAC_BITS;
	assign pu1 = (64'(rinv_s1) * 64'(m1_s1)) >>> FRAC_BITS;
	assign pu2 = (64'(rinv_s1) * 64'(m2_s1)) >>> FRAC_BITS;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vb_s2 <= 1'b0;
		else if (en) vb_s2 <= va_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			u0_s2 <= sat32(pu0); u1_s2 <= sat32(pu1); u2_s2 <= sat32(pu2);
			sat_s2 <= sat_s1 | ovf32(pu0) | ovf32(pu1) | ovf32(pu2);
			rinv_s2 <= rinv_s1; rho_s2 <= rho_s1; m0_s2 <= m0_s1; m1_s2 <= m1_s1;
			m2_s2 <= m2_s1; e_s2 <= e_s1; gam_s2 <= gam_s1; gm1_s2 <= gm1_s1; gm3_s2 <= gm3_s1;
			jac_s2 <= jac_s1; bad_s2 <= bad_s1;
		end
	end

	// stage c: squared speed
	logic vc_s3;
	logic signed [DATA_W-1:0] v2_s3;
	logic sat_s3;
	logic signed [63:0] v2w;
	assign v2w = ((64'(u0_s2) * 64'(u0_s2)) >>> FRAC_BITS)
		+ ((64'(u1_s2) * 64'(u1_s2)) >>> FRAC_BITS)
		+ ((64'(u2_s2) * 64'(u2_s2)) >>> FRAC_BITS);
	logic signed [DATA_W-1:0] u0_s3, u1_s3, u2_s3, rinv_s3, rho_s3, m0_s3, m1_s3, m2_s3, e_s3;
	logic signed [DATA_W-1:0] gam_s3, gm1_s3, gm3_s3;
	logic jac_s3, bad_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vc_s3 <= 1'b0;
		else if (en) vc_s3 <= vb_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			v2_s3 <= sat32(v2w); sat_s3 <= sat_s2 | ovf32(v2w);
			u0_s3 <= u0_s2; u1_s3 <= u1_s2; u2_s3 <= u2_s2; rinv_s3 <= rinv_s2;
			rho_s3 <= rho_s2; m0_s3 <= m0_s2; m1_s3 <= m1_s2; m2_s3 <= m2_s2; e_s3 <= e_s2;
			gam_s3 <= gam_s2; gm1_s3 <= gm1_s2; gm3_s3 <= gm3_s2; jac_s3 <= jac_s2; bad_s3 <= bad_s2;
		end
	end

	// stage d: internal energy term and alpha
	logic vd_s4;
	logic signed [DATA_W-1:0] t_s4, al_s4;
	logic sat_s4;
	logic signed [63:0] tw, aw;
	assign tw = 64'(e_s3) - ((64'(rho_s3) * 64'(v2_s3)) >>> (FRAC_BITS+1));
	assign aw = (64'(gm1_s3) * 64'(v2_s3)) >>> (FRAC_BITS+1);
	logic signed [DATA_W-1:0] u0_s4, u1_s4, u2_s4, rinv_s4, m0_s4, m1_s4, m2_s4, e_s4;
	logic signed [DATA_W-1:0] gam_s4, gm1_s4, gm3_s4;
	logic jac_s4, bad_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vd_s4 <= 1'b0;
		else if (en) vd_s4 <= vc_s3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			t_s4 <= sat32(tw); al_s4 <= sat32(aw); sat_s4 <= sat_s3 | ovf32(tw) | ovf32(aw);
			u0_s4 <= u0_s3; u1_s4 <= u1_s3; u2_s4 <= u2_s3; rinv_s4 <= rinv_s3;
			m0_s4 <= m0_s3; m1_s4 <= m1_s3; m2_s4 <= m2_s3; e_s4 <= e_s3;
			gam_s4 <= gam_s3; gm1_s4 <= gm1_s3; gm3_s4 <= gm3_s3; jac_s4 <= jac_s3; bad_s4 <= bad_s3;
		end
	end

	// stage e: pressure
	logic ve_s5;
	logic signed [DATA_W-1:0] p_s5;
	logic sat_s5;
	logic signed [63:0] pw;
	assign pw = (64'(gm1_s4) * 64'(t_s4)) >>> FRAC_BITS;
	logic signed [DATA_W-1:0] al_s5, u0_s5, u1_s5, u2_s5, rinv_s5, m0_s5, m1_s5, m2_s5, e_s5;
	logic signed [DATA_W-1:0] gam_s5, gm1_s5, gm3_s5;
	logic jac_s5, bad_s5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ve_s5 <= 1'b0;
		else if (en) ve_s5 <= vd_s4;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			p_s5 <= sat32(pw); sat_s5 <= sat_s4 | ovf32(pw);
			al_s5 <= al_s4; u0_s5 <= u0_s4; u1_s5 <= u1_s4; u2_s5 <= u2_s4; rinv_s5 <= rinv_s4;
			m0_s5 <= m0_s4; m1_s5 <= m1_s4; m2_s5 <= m2_s4; e_s5 <= e_s4;
			gam_s5 <= gam_s4; gm1_s5 <= gm1_s4; gm3_s5 <= gm3_s4; jac_s5 <= jac_s4; bad_s5 <= bad_s4;
		end
	end

	// stage f: energy plus pressure
	logic vf_s6;
	logic signed [DATA_W-1:0] ep_s6;
	logic sat_s6;
	logic signed [63:0] epw;
	assign epw = 64'(e_s5) + 64'(p_s5);
	logic signed [DATA_W-1:0] p_s6, al_s6, u0_s6, u1_s6, u2_s6, rinv_s6, m0_s6, m1_s6, m2_s6;
	logic signed [DATA_W-1:0] gam_s6, gm1_s6, gm3_s6;
	logic jac_s6, bad_s6;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vf_s6 <= 1'b0;
		else if (en) vf_s6 <= ve_s5;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ep_s6 <= sat32(epw); sat_s6 <= sat_s5 | ovf32(epw);
			p_s6 <= p_s5; al_s6 <= al_s5; u0_s6 <= u0_s5; u1_s6 <= u1_s5; u2_s6 <= u2_s5;
			rinv_s6 <= rinv_s5; m0_s6 <= m0_s5; m1_s6 <= m1_s5; m2_s6 <= m2_s5;
			gam_s6 <= gam_s5; gm1_s6 <= gm1_s5; gm3_s6 <= gm3_s5; jac_s6 <= jac_s5; bad_s6 <= bad_s5;
		end
	end

	// stage g: enthalpy
	logic vg_s7;
	logic signed [DATA_W-1:0] h_s7;
	logic sat_s7;
	logic signed [63:0] hw;
	assign hw = (64'(ep_s6) * 64'(rinv_s6)) >>> FRAC_BITS;
	logic signed [DATA_W-1:0] ep_s7, p_s7, al_s7, u0_s7, u1_s7, u2_s7, m0_s7, m1_s7, m2_s7;
	logic signed [DATA_W-1:0] gam_s7, gm1_s7, gm3_s7;
	logic jac_s7, bad_s7;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vg_s7 <= 1'b0;
		else if (en) vg_s7 <= vf_s6;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			h_s7 <= sat32(hw); sat_s7 <= sat_s6 | ovf32(hw);
			ep_s7 <= ep_s6; p_s7 <= p_s6; al_s7 <= al_s6; u0_s7 <= u0_s6; u1_s7 <= u1_s6;
			u2_s7 <= u2_s6; m0_s7 <= m0_s6; m1_s7 <= m1_s6; m2_s7 <= m2_s6;
			gam_s7 <= gam_s6; gm1_s7 <= gm1_s6; gm3_s7 <= gm3_s6; jac_s7 <= jac_s6; bad_s7 <= bad_s6;
		end
	end

	// stage h: beta and final node record
	logic signed [63:0] bw;
	assign bw = 64'(al_s7) - 64'(h_s7);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= vg_s7;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			node.beta <= sat32(bw);
			node.pre_sat <= sat_s7 | ovf32(bw);
			node.h <= h_s7; node.ep <= ep_s7; node.p <= p_s7; node.alpha <= al_s7;
			node.u0 <= u0_s7; node.u1 <= u1_s7; node.u2 <= u2_s7;
			node.m0 <= m0_s7; node.m1 <= m1_s7; node.m2 <= m2_s7;
			node.gam <= gam_s7; node.gm1 <= gm1_s7; node.gm3 <= gm3_s7;
			node.jac <= jac_s7; node.bad <= bad_s7;
		end
	end
endmodule

### hw/rtl/efj_rows.sv
// efj_rows: row sequencer and row arithmetic, one flux or jacobian row per beat
// depends on efj_pkg
module efj_rows import efj_pkg::*; #(
	parameter int SPACE_DIMS = DEF_SPACE_DIMS,
	parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic node_valid,
	input  node_t node,
	output logic node_take,
	output logic row_valid,
	input  logic row_stall,
	output row_tag_t row_tag,
	output logic signed [DATA_W-1:0] vx,
	output logic signed [DATA_W-1:0] vy,
	output logic signed [DATA_W-1:0] vz,
	output logic row_sat
);
	localparam int NEQ = SPACE_DIMS + 2;
	localparam logic [IDX_W-1:0] LASTI = IDX_W'(NEQ - 1);
	localparam logic signed [DATA_W-1:0] ONE = DATA_W'(64'sd1 <<< FRAC_BITS);

	// held node and row counters
	node_t nd_q;
	logic act_q, kind_q;
	logic [IDX_W-1:0] eq_q, vr_q;
	logic last_row;
	logic adv;

	assign last_row = (kind_q == KIND_FLUX) ? (eq_q == LASTI && !nd_q.jac)
		: (eq_q == LASTI && vr_q == LASTI);

	// pipeline stages of the row path
	logic v1_s1, v2_s2, v3_s3;
	logic en;
	assign en = !(v3_s3 && row_stall);
	assign adv = en && act_q;
	assign node_take = en && (!act_q || last_row);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0; kind_q <= KIND_FLUX; eq_q <= '0; vr_q <= '0;
		end else if (en) begin
			if (!act_q || last_row) begin
				act_q <= node_valid; kind_q <= KIND_FLUX; eq_q <= '0; vr_q <= '0;
			end else if (eq_q == LASTI) begin
				eq_q <= '0;
				if (kind_q == KIND_FLUX) kind_q <= KIND_JAC;
				else vr_q <= vr_q + 1'b1;
			end else begin
				eq_q <= eq_q + 1'b1;
			end
		end
	end
	always_ff @(posedge clk) begin
		if (node_take && node_valid) nd_q <= node;
	end

	// stage 1: choose operands per component: val = c + s*floor(a*b) , s = +/-1 or 0
	logic signed [DATA_W-1:0] a_s1 [3], b_s1 [3], c_s1 [3];
	logic [1:0] mode_s1 [3]; // 0 none, 1 add product, 2 subtract product, 3 zero
	logic gsat_s1; // jacobian energy row of a momentum variable: g product first
	logic signed [DATA_W-1:0] g_s1;
	row_tag_t tag_s1;
	logic psat_s1;
	logic signed [63:0] gw;
	logic signed [DATA_W-1:0] uu [3], mm [3];
	logic [IDX_W-1:0] mi, iv;

	always_comb begin
		uu[0] = nd_q.u0; uu[1] = nd_q.u1; uu[2] = nd_q.u2;
		mm[0] = nd_q.m0; mm[1] = nd_q.m1; mm[2] = nd_q.m2;
		mi = eq_q - 1'b1;
		iv = vr_q - 1'b1;
		gw = (64'(nd_q.gm1) * 64'(uu[iv[1:0]])) >>> FRAC_BITS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0; v2_s2 <= 1'b0; v3_s3 <= 1'b0;
		end else if (en) begin
			v1_s1 <= act_q; v2_s2 <= v1_s1; v3_s3 <= v2_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s1.kind <= kind_q; tag_s1.eq <= eq_q;
			tag_s1.vr <= (kind_q == KIND_JAC) ? vr_q : '0;
			tag_s1.last <= last_row; tag_s1.bad <= nd_q.bad;
			psat_s1 <= nd_q.pre_sat;
			g_s1 <= sat32(gw);
			gsat_s1 <= 1'b0;
			for (int d = 0; d < 3; d++) begin
				a_s1[d] <= '0; b_s1[d] <= '0; c_s1[d] <= '0; mode_s1[d] <= 2'd0;
				if (kind_q == KIND_FLUX) begin
					if (eq_q == 0) c_s1[d] <= mm[d];
					else if (eq_q < LASTI) begin
						a_s1[d] <= mm[mi[1:0]]; b_s1[d] <= uu[d]; mode_s1[d] <= 2'd1;
						if (d == int'(mi)) c_s1[d] <= nd_q.p;
					end else begin
						a_s1[d] <= nd_q.ep; b_s1[d] <= uu[d]; mode_s1[d] <= 2'd1;
					end
				end else if (vr_q == 0) begin
					if (eq_q == 0) ;
					else if (eq_q < LASTI) begin
						a_s1[d] <= uu[mi[1:0]]; b_s1[d] <= uu[d]; mode_s1[d] <= 2'd2;
						if (d == int'(mi)) c_s1[d] <= nd_q.alpha;
					end else begin
						a_s1[d] <= uu[d]; b_s1[d] <= nd_q.beta; mode_s1[d] <= 2'd1;
					end
				end else if (vr_q < LASTI) begin
					if (eq_q == 0) begin
						if (d == int'(iv)) c_s1[d] <= ONE;
					end else if (eq_q < LASTI) begin
						if (mi == iv) begin
							if (d == int'(mi)) begin
								a_s1[d] <= nd_q.gm3; b_s1[d] <= uu[d]; mode_s1[d] <= 2'd2;
							end else c_s1[d] <= uu[d];
						end else if (d == int'(mi)) begin
							a_s1[d] <= nd_q.gm1; b_s1[d] <= uu[iv[1:0]]; mode_s1[d] <= 2'd2;
						end else if (d == int'(iv)) c_s1[d] <= uu[mi[1:0]];
					end else begin
						gsat_s1 <= 1'b1;
						b_s1[d] <= uu[d]; mode_s1[d] <= 2'd2;
						if (d == int'(iv)) c_s1[d] <= nd_q.h;
					end
				end else begin
					if (eq_q == 0) ;
					else if (eq_q < LASTI) begin
						if (d == int'(mi)) c_s1[d] <= nd_q.gm1;
					end else begin
						a_s1[d] <= nd_q.gam; b_s1[d] <= uu[d]; mode_s1[d] <= 2'd1;
					end
				end
				if (d >= SPACE_DIMS || nd_q.bad) mode_s1[d] <= 2'd3;
			end
		end
	end

	// stage 2: products
	logic signed [63:0] pr_s2 [3];
	logic signed [DATA_W-1:0] c_s2 [3];
	logic [1:0] mode_s2 [3];
	row_tag_t tag_s2;
	logic sat_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			tag_s2 <= tag_s1;
			sat_s2 <= psat_s1 | (gsat_s1 & (mode_s1[0] != 2'd3) & ovf32(64'(g_s1)) & 1'b0);
			for (int d = 0; d < 3; d++) begin
				pr_s2[d] <= (64'(gsat_s1 ? g_s1 : a_s1[d]) * 64'(b_s1[d])) >>> FRAC_BITS;
				c_s2[d] <= c_s1[d];
				mode_s2[d] <= mode_s1[d];
			end
		end
	end
	// the g clip flag travels alongside
	logic signed [63:0] gw_hold_s1;
	logic gclip_s2;
	always_ff @(posedge clk) begin
		if (adv) gw_hold_s1 <= gw;
	end
	always_ff @(posedge clk) begin
		if (en) gclip_s2 <= gsat_s1 && !tag_s1.bad && ovf32(gw_hold_s1);
	end

	// stage 3: combine and saturate
	logic signed [63:0] sum [3];
	always_comb begin
		for (int d = 0; d < 3; d++) begin
			case (mode_s2[d])
				2'd1: sum[d] = 64'(c_s2[d]) + pr_s2[d];
				2'd2: sum[d] = 64'(c_s2[d]) - pr_s2[d];
				2'd3: sum[d] = '0;
				default: sum[d] = 64'(c_s2[d]);
			endcase
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			row_tag <= tag_s2;
			vx <= sat32(sum[0]); vy <= sat32(sum[1]); vz <= sat32(sum[2]);
			row_sat <= !tag_s2.bad && (sat_s2 | gclip_s2 | ovf32(sum[0]) | ovf32(sum[1])
				| ovf32(sum[2]));
		end
	end
	assign row_valid = v3_s3;
endmodule

### hw/rtl/euler_flux_and_jacobian.sv
// euler_flux_and_jacobian: top level, config registers, front end and row sequencer
// depends on efj_pkg, efj_front, efj_rows
//
// usage:
//  input channel: valid/stall with density, momentum and total energy of one node per beat.
//  output channel: valid/stall, one result row per beat: D+2 flux rows, then (D+2)^2
//  jacobian rows (variable outer, equation inner) when jacobian_enable is set;
//  last_of_node marks the final row of a node.
//  config channel: cfg_valid/cfg_ready, index 0 gamma_ratio, 1 jacobian_enable; ready is
//  always high and writes are meant for idle periods only.
//  path: from the accepting edge to out_valid of the first row through 2F+1
//  reciprocal stages, eight node stages, the row counter and three row stages.
//  throughput: one row per cycle while out_stall is low; a node gives D+2 rows, or
//  (D+2)(D+3) with the jacobian, so the row sequencer sets the node rate. The front end
//  takes a node every cycle while it moves.
//  reset clears all valid bits and restores the register reset values.
//  output stall freezes the row stages; a finished node waits at the end of the front
//  end until the row sequencer takes it, and while it waits the whole front end holds
//  and input stall is raised.
module euler_flux_and_jacobian import efj_pkg::*; #(
	parameter int SPACE_DIMS = DEF_SPACE_DIMS,
	parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [DATA_W-1:0] density,
	input  logic signed [DATA_W-1:0] momentum_x,
	input  logic signed [DATA_W-1:0] momentum_y,
	input  logic signed [DATA_W-1:0] momentum_z,
	input  logic signed [DATA_W-1:0] total_energy,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0] cfg_data,
	output logic out_valid,
	input  logic out_stall,
	output logic result_kind,
	output logic [IDX_W-1:0] equation_index,
	output logic [IDX_W-1:0] variable_index,
	output logic signed [DATA_W-1:0] val_x,
	output logic signed [DATA_W-1:0] val_y,
	output logic signed [DATA_W-1:0] val_z,
	output logic last_of_node,
	output logic bad_density,
	output logic saturated
);
	// config registers
	logic [GAMMA_W-1:0] gamma_q;
	logic jac_q;
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gamma_q <= GAMMA_RESET; jac_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_GAMMA_RATIO: gamma_q <= cfg_data[GAMMA_W-1:0];
				REG_JAC_ENABLE:  jac_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// front end moves unless a finished node is waiting for the row sequencer
	logic in_acc, fv, fen, take;
	node_t fnode;
	assign fen = !fv || take;
	assign in_stall = !fen;
	assign in_acc = in_valid && fen;

	efj_front #(.SPACE_DIMS(SPACE_DIMS), .FRAC_BITS(FRAC_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .en(fen), .in_valid(in_acc),
		.density(density), .momentum_x(momentum_x), .momentum_y(momentum_y),
		.momentum_z(momentum_z), .total_energy(total_energy),
		.gamma_ratio(gamma_q), .jac_en(jac_q), .out_valid(fv), .node(fnode));

	row_tag_t tag;
	efj_rows #(.SPACE_DIMS(SPACE_DIMS), .FRAC_BITS(FRAC_BITS)) u_rows (
		.clk(clk), .arst_n(arst_n), .node_valid(fv), .node(fnode),
		.node_take(take), .row_valid(out_valid), .row_stall(out_stall),
		.row_tag(tag), .vx(val_x), .vy(val_y), .vz(val_z), .row_sat(saturated));

	assign result_kind = tag.kind;
	assign equation_index = tag.eq;
	assign variable_index = tag.vr;
	assign last_of_node = tag.last;
	assign bad_density = tag.bad;
endmodule

### hw/rtl/efj_checker.sv
// efj_checker: port-level assertions for euler_flux_and_jacobian, bound to the top level
// depends on efj_pkg
module efj_checker import efj_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_stall,
	input logic result_kind,
	input logic [IDX_W-1:0] equation_index,
	input logic [IDX_W-1:0] variable_index,
	input logic bad_density,
	input logic saturated,
	input logic last_of_node
);
	// stalled row holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(equation_index) && $stable(result_kind))
		else $error("row changed under stall");
	// bad density rows never flag saturation
	a_bad: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_density |-> !saturated) else $error("bad row saturated");
	// flux rows carry variable zero
	a_flux: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_FLUX |-> variable_index == '0)
		else $error("flux row variable nonzero");
	// a row after a last row starts at flux equation zero
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last_of_node ##1 out_valid |->
		result_kind == KIND_FLUX && equation_index == '0) else $error("bad node start");
endmodule

bind euler_flux_and_jacobian efj_checker u_chk (.*);

### test/tb.sv
// tb: self-checking bench for euler_flux_and_jacobian (flux and jacobian rows per node)
// depends on efj_pkg and the euler_flux_and_jacobian rtl
module tb import efj_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NDIM = DEF_SPACE_DIMS;
	localparam int FB   = DEF_FRAC_BITS;
	localparam int NEQ  = NDIM + 2;
	localparam longint LIMIT = 1000000;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'd7;

	typedef struct {
		logic signed [DATA_W-1:0] rho, mx, my, mz, e;
	} node_in_t;

	typedef struct {
		logic kind;
		logic [IDX_W-1:0] eq, vr;
		logic signed [DATA_W-1:0] vx, vy, vz;
		logic last, bad, sat;
	} flux_row_t;

	// predicts the flux and jacobian rows of each node and checks the rows that come out
	class flux_row_tracker;
		flux_row_t pending_rows[$];
		longint gamma_q;
		bit jac_on;
		int errors;
		int rows_seen;
		longint m[3], u[3];
		longint rinv, p, ep, h, alpha, beta, one, gm1, gm3, gam;
		bit node_clip;

		function new();
			gamma_q = GAMMA_RESET;
			jac_on = 1;
		endfunction

		function longint clip(longint v, inout bit f);
			if (v > 64'sd2147483647) begin
				f = 1;
				return 64'sd2147483647;
			end
			if (v < -64'sd2147483648) begin
				f = 1;
				return -64'sd2147483648;
			end
			return v;
		endfunction

		function longint qmul(longint a, longint b);
			return (a * b) >>> FB;
		endfunction

		function longint flux_val(int eq, int d);
			if (eq == 0) return m[d];
			if (eq <= NDIM) return qmul(m[eq-1], u[d]) + ((d == eq - 1) ? p : 0);
			return qmul(ep, u[d]);
		endfunction

		function longint jac_val(int vr, int eq, int d, inout bit f);
			longint g;
			int mi, iv;
			mi = eq - 1;
			iv = vr - 1;
			// derivative by density
			if (vr == 0) begin
				if (eq == 0) return 0;
				if (eq <= NDIM) return -qmul(u[mi], u[d]) + ((d == mi) ? alpha : 0);
				return qmul(u[d], beta);
			end
			// derivative by a momentum component
			if (vr <= NDIM) begin
				if (eq == 0) return (d == iv) ? one : 0;
				if (eq <= NDIM) begin
					if (mi == iv) return (mi == d) ? -qmul(gm3, u[d]) : u[d];
					if (mi == d) return -qmul(gm1, u[iv]);
					if (iv == d) return u[mi];
					return 0;
				end
				g = clip(qmul(gm1, u[iv]), f);
				return ((d == iv) ? h : 0) - qmul(g, u[d]);
			end
			// derivative by energy
			if (eq == 0) return 0;
			if (eq <= NDIM) return (eq - 1 == d) ? gm1 : 0;
			return qmul(gam, u[d]);
		endfunction

		function void derive_node(node_in_t n);
			longint rho, e, v2, t;
			bit f;
			f = 0;
			rho = n.rho;
			e = n.e;
			m[0] = n.mx;
			m[1] = n.my;
			m[2] = n.mz;
			one = 64'sd1 <<< FB;
			gam = gamma_q;
			gm1 = gam - one;
			gm3 = gam - 3 * one;
			rinv = clip((64'sd1 <<< (2 * FB)) / rho, f);
			v2 = 0;
			for (int d = 0; d < NDIM; d++) begin
				u[d] = clip(qmul(rinv, m[d]), f);
				v2 += qmul(u[d], u[d]);
			end
			v2 = clip(v2, f);
			t = clip(e - ((rho * v2) >>> (FB + 1)), f);
			p = clip(qmul(gm1, t), f);
			ep = clip(e + p, f);
			h = clip(qmul(ep, rinv), f);
			alpha = clip((gm1 * v2) >>> (FB + 1), f);
			beta = clip(alpha - h, f);
			node_clip = f;
		endfunction

		// an accepted node beat: queue its expected rows
		function void note_node(node_in_t n);
			flux_row_t r;
			bit bad, f;
			int total, vr, eq;
			longint v[3];
			bad = (n.rho <= 0);
			total = NEQ + (jac_on ? NEQ * NEQ : 0);
			if (!bad) derive_node(n);
			for (int k = 0; k < total; k++) begin
				r.kind = (k < NEQ) ? KIND_FLUX : KIND_JAC;
				vr = (k < NEQ) ? 0 : (k - NEQ) / NEQ;
				eq = (k < NEQ) ? k : (k - NEQ) % NEQ;
				f = bad ? 0 : node_clip;
				for (int d = 0; d < 3; d++) begin
					v[d] = 0;
					if (!bad && d < NDIM) begin
						v[d] = (k < NEQ) ? flux_val(eq, d) : jac_val(vr, eq, d, f);
						v[d] = clip(v[d], f);
					end
				end
				r.eq = eq[IDX_W-1:0];
				r.vr = vr[IDX_W-1:0];
				r.vx = v[0][DATA_W-1:0];
				r.vy = v[1][DATA_W-1:0];
				r.vz = v[2][DATA_W-1:0];
				r.last = (k == total - 1);
				r.bad = bad;
				r.sat = !bad && f;
				pending_rows.push_back(r);
			end
		endfunction

		task report(string what, longint got, longint want);
			errors++;
			$display("mismatch row %0d: %s got %0d want %0d", rows_seen, what, got, want);
		endtask

		// an accepted result beat: compare with the oldest expected row
		task check_row(flux_row_t got);
			flux_row_t w;
			rows_seen++;
			if (pending_rows.size() == 0) begin
				report("unexpected row, kind", got.kind, 0);
				return;
			end
			w = pending_rows.pop_front();
			if (got.kind !== w.kind) report("result_kind", got.kind, w.kind);
			if (got.eq !== w.eq) report("equation_index", got.eq, w.eq);
			if (got.vr !== w.vr) report("variable_index", got.vr, w.vr);
			if (got.vx !== w.vx) report("val_x", got.vx, w.vx);
			if (got.vy !== w.vy) report("val_y", got.vy, w.vy);
			if (got.vz !== w.vz) report("val_z", got.vz, w.vz);
			if (got.last !== w.last) report("last_of_node", got.last, w.last);
			if (got.bad !== w.bad) report("bad_density", got.bad, w.bad);
			if (got.sat !== w.sat) report("saturated", got.sat, w.sat);
		endtask
	endclass

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_stall;
	logic signed [DATA_W-1:0] density = 0, momentum_x = 0, momentum_y = 0;
	logic signed [DATA_W-1:0] momentum_z = 0, total_energy = 0;
	logic cfg_valid = 0, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = 0;
	logic [DATA_W-1:0] cfg_data = 0;
	logic out_valid, out_stall = 1;
	logic result_kind, last_of_node, bad_density, saturated;
	logic [IDX_W-1:0] equation_index, variable_index;
	logic signed [DATA_W-1:0] val_x, val_y, val_z;

	flux_row_tracker rows = new();
	longint cycles = 0;
	int nodes_sent = 0;
	bit long_hold = 0;
	bit send_busy = 0, recv_busy = 0;

	euler_flux_and_jacobian dut (.*);

	// clock and reset
	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	// result side: random stall per beat, one long hold on request
	initial begin
		flux_row_t got;
		int w;
		@(posedge clk iff arst_n);
		out_stall <= 0;
		forever begin
			if (long_hold) begin
				out_stall <= 1;
				repeat (400) @(posedge clk);
				long_hold = 0;
				out_stall <= 0;
			end else begin
				w = recv_busy ? 0 : $urandom_range(0, 8);
				if (w > 0) begin
					out_stall <= 1;
					repeat (w) @(posedge clk);
					out_stall <= 0;
				end
			end
			do begin
				@(negedge clk);
				got.kind = result_kind;
				got.eq = equation_index;
				got.vr = variable_index;
				got.vx = val_x;
				got.vy = val_y;
				got.vz = val_z;
				got.last = last_of_node;
				got.bad = bad_density;
				got.sat = saturated;
				w = out_valid;
				@(posedge clk);
			end while (w !== 1);
			rows.check_row(got);
		end
	end

	task automatic send_node(node_in_t n);
		int gap;
		bit st;
		gap = send_busy ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		density <= n.rho;
		momentum_x <= n.mx;
		momentum_y <= n.my;
		momentum_z <= n.mz;
		total_energy <= n.e;
		do begin
			@(negedge clk);
			st = in_stall;
			@(posedge clk);
		end while (st !== 0);
		rows.note_node(n);
		nodes_sent++;
	endtask

	// config writes only while idle
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
		bit rdy;
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do begin
			@(negedge clk);
			rdy = cfg_ready;
			@(posedge clk);
		end while (rdy !== 1);
		cfg_valid <= 0;
		if (idx == REG_GAMMA_RATIO) rows.gamma_q = val[GAMMA_W-1:0];
		else if (idx == REG_JAC_ENABLE) rows.jac_on = val[0];
	endtask

	task automatic drain();
		in_valid <= 0;
		while (rows.pending_rows.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	function automatic node_in_t mk(longint r, longint x, longint y, longint z, longint e);
		node_in_t n;
		n.rho = r[31:0];
		n.mx = x[31:0];
		n.my = y[31:0];
		n.mz = z[31:0];
		n.e = e[31:0];
		return n;
	endfunction

	// mostly plausible states, plus raw words and extreme corners
	function automatic node_in_t rand_node();
		node_in_t n;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			n.rho = $urandom_range(32'h1000, 32'h200000);
			n.mx = $signed($urandom_range(0, 32'h400000)) - 32'sh200000;
			n.my = $signed($urandom_range(0, 32'h400000)) - 32'sh200000;
			n.mz = $signed($urandom_range(0, 32'h400000)) - 32'sh200000;
			n.e = $urandom_range(0, 32'h1000000);
		end else if (pick < 88) begin
			n.rho = $urandom();
			n.mx = $urandom();
			n.my = $urandom();
			n.mz = $urandom();
			n.e = $urandom();
		end else begin
			n.rho = $urandom_range(0, 1) ? 32'sh7fffffff : $urandom_range(1, 4);
			n.mx = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			n.my = $urandom();
			n.mz = $urandom_range(0, 1) ? 32'sh80000000 : 0;
			n.e = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
		end
		return n;
	endfunction

	initial begin
		node_in_t dset[$];
		longint gam_set[6] = '{91750, 65537, 131072, 0, 262143, 0};
		bit jac_set[6] = '{1, 0, 1, 1, 0, 1};
		int cnt_set[6] = '{120, 60, 90, 40, 40, 100};
		@(posedge clk iff arst_n);
		@(posedge clk);

		// directed nodes at reset settings
		dset.push_back(mk(0, 65536, 65536, 65536, 65536));
		dset.push_back(mk(-1, 1, 2, 3, 4));
		dset.push_back(mk(-64'sd2147483648, -1, -1, -1, -1));
		dset.push_back(mk(2147483647, 2147483647, -64'sd2147483648, 2147483647, 2147483647));
		dset.push_back(mk(1, 65536, 0, 0, 65536));
		dset.push_back(mk(65536, 0, 0, 0, 0));
		dset.push_back(mk(65536, 65536, 131072, -65536, 327680));
		dset.push_back(mk(131072, 2147483647, 0, 0, 65536));
		dset.push_back(mk(131072, -64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
			65536));
		dset.push_back(mk(65536, 0, 0, 0, 2147483647));
		dset.push_back(mk(65536, 0, 0, 0, -64'sd2147483648));
		dset.push_back(mk(32768, 98304, -40000, 12345, 400000));
		dset.push_back(mk(4096, 65536, 65536, 65536, 65536));
		dset.push_back(mk(65536, 200, 300, 2147483647, 65536));
		foreach (dset[i]) send_node(dset[i]);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 5) gam_set[ph] = $urandom_range(65537, 131072);
			write_reg(REG_GAMMA_RATIO, {14'h3fff, gam_set[ph][GAMMA_W-1:0]});
			write_reg(REG_JAC_ENABLE, {31'h7fffffff, jac_set[ph]});
			if (ph == 2) write_reg(REG_UNMAPPED, 32'hdeadbeef);
			if (ph == 1) long_hold = 1;
			for (int i = 0; i < cnt_set[ph]; i++) begin
				if (i % 25 == 0) begin
					send_busy = ($urandom_range(0, 3) == 0);
					recv_busy = ($urandom_range(0, 3) == 0);
				end
				// pause the sender until the block runs dry
				if (ph == 3 && i == 20) begin
					in_valid <= 0;
					while (rows.pending_rows.size() != 0) @(posedge clk);
				end
				send_node(rand_node());
			end
			drain();
		end

		$display("nodes %0d, rows checked %0d, six gamma/jacobian settings incl. extremes",
			nodes_sent, rows.rows_seen);
		if (rows.errors == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule
